// ----- rtl/kfis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfis_pkg
// Shared types, constants and helpers of the Kalman filter step core.
// ----------------------------------------------------------------------------
package kfis_pkg;

    localparam int STATE_DIM = 4;
    localparam int MEAS_DIM  = 2;

    localparam int IDX_W = $clog2(STATE_DIM);
    localparam int K_W   = $clog2(STATE_DIM + 1);
    localparam int NN_W  = $clog2(STATE_DIM * STATE_DIM);
    localparam int MN_W  = $clog2(MEAS_DIM * STATE_DIM);
    localparam int MM_W  = $clog2(MEAS_DIM * MEAS_DIM);
    localparam int M_W   = $clog2(MEAS_DIM);

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int QW     = 50;
    localparam int MAG_W  = QW - 1;
    localparam int DCNT_W = $clog2(MAG_W);
    localparam int FRAC_W = 16;

    localparam logic signed [DATA_W-1:0] INIT_VARIANCE = 32'sd6553600;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF    = 64'sd32768;

    localparam logic [2:0] CMD_WRITE_MODEL = 3'd0;
    localparam logic [2:0] CMD_INIT        = 3'd1;
    localparam logic [2:0] CMD_WRITE_GUESS = 3'd2;
    localparam logic [2:0] CMD_STEP        = 3'd3;
    localparam logic [2:0] CMD_READ        = 3'd4;

    localparam logic [2:0] SEL_A   = 3'd0;
    localparam logic [2:0] SEL_B   = 3'd1;
    localparam logic [2:0] SEL_C   = 3'd2;
    localparam logic [2:0] SEL_Q   = 3'd3;
    localparam logic [2:0] SEL_R   = 3'd4;
    localparam logic [2:0] SEL_EST = 3'd0;
    localparam logic [2:0] SEL_COV = 3'd1;

    localparam logic KIND_EST  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRED_X,
        PH_AP,
        PH_APAT,
        PH_PCT,
        PH_S,
        PH_DET,
        PH_DIV,
        PH_GAIN,
        PH_INNOV,
        PH_XCORR,
        PH_CP,
        PH_PUPD,
        PH_EMIT,
        PH_READ
    } phase_t;

    typedef struct packed {
        logic [2:0]          command;
        logic [2:0]          matrix_sel;
        logic [2:0]          row_index;
        logic [2:0]          col_index;
        logic signed [31:0]  value;
        logic signed [31:0]  control_input;
        logic signed [31:0]  meas_first;
        logic signed [31:0]  meas_second;
    } cmd_t;

    typedef struct packed {
        logic                kind;
        logic [5:0]          element_index;
        logic signed [31:0]  data;
        logic                singular;
        logic                last;
    } res_t;

    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      last;
        logic                      sub;
        phase_t                    tag;
        logic [NN_W-1:0]           addr;
        logic signed [DATA_W-1:0]  init;
    } mac_req_t;

    typedef struct packed {
        logic                      valid;
        phase_t                    tag;
        logic [NN_W-1:0]           addr;
        logic signed [ACC_W-1:0]   acc;
    } mac_wb_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic int fidx(input int r, input int c, input int w);
        return r * w + c;
    endfunction

endpackage

// ----- rtl/kalman_filter_with_input_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_with_input_step_core
// Linear Kalman filter step, Q16.16, one shared MAC and one serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) takes command items; res channel
//   (res_valid / res_stall / res) gives result items. cfg_write with cfg_data
//   sets the second-measurement-zero flag; the user must do so only while the
//   core is idle, which the core does not enforce. Model writes, guess writes
//   and init give no result. A read gives one result item from PH_READ.
//   A step gives STATE_DIM estimate items, the last one marked; at
//   STATE_DIM = 4 it runs about 300 products through the one multiplier,
//   a short pipeline drain after each matrix product, and four divisions
//   in the one-bit-per-cycle divider (none if the determinant is zero).
//   cmd_stall is high while a step or a read is in progress.
//   A result waits in the output register while res_stall is high; the core
//   accepts the next item meanwhile but holds any new result until taken.
//   Reset clears the estimate to zero, the covariance to 100 times identity
//   and the flag; the model store holds garbage until written.
// ----------------------------------------------------------------------------
module kalman_filter_with_input_step_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  kfis_pkg::cmd_t    cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output kfis_pkg::res_t    res,
    input  logic              cfg_write,
    input  logic              cfg_data
);
    import kfis_pkg::*;

    localparam int N = STATE_DIM;
    localparam int M = MEAS_DIM;

    phase_t state_reg, state_next;

    logic [IDX_W-1:0] i_reg, j_reg, i_lim, j_lim;
    logic [K_W-1:0]   k_reg, k_lim;
    logic [MM_W-1:0]  inv_cnt_reg;
    logic             issue_done_reg;
    logic             div_run_reg;
    logic             smz_reg;
    logic             sing_reg;

    logic signed [31:0] u_reg;
    logic signed [31:0] y_reg [M];
    logic [2:0]         rd_sel_reg, rd_row_reg, rd_col_reg;

    logic signed [31:0] trans_reg  [N*N];
    logic signed [31:0] inp_reg    [N];
    logic signed [31:0] meas_reg   [M*N];
    logic signed [31:0] pnoise_reg [N*N];
    logic signed [31:0] mnoise_reg [M*M];
    logic signed [31:0] est_reg    [N];
    logic signed [31:0] cov_reg    [N*N];
    logic signed [31:0] tv_reg     [N];
    logic signed [31:0] ap_reg     [N*N];
    logic signed [31:0] pct_reg    [M*N];
    logic signed [31:0] s_reg      [M*M];
    logic signed [31:0] inv_reg    [M*M];
    logic signed [31:0] gain_reg   [M*N];
    logic signed [31:0] ni_reg     [M];
    logic signed [31:0] cp_reg     [M*N];
    logic signed [QW-1:0] det_reg;

    res_t res_reg;
    logic res_valid_reg;

    mac_req_t           iss_reg, iss_next;
    logic signed [31:0] opa_reg, opb_reg, opa, opb, init_val;
    logic               sub;
    logic [NN_W-1:0]    dest;
    mac_wb_t            wb;
    logic               mac_busy;

    logic               div_start, div_done;
    logic signed [QW-1:0] div_num, div_sx, div_sh;
    logic signed [31:0] div_quo;

    logic               cmd_acc, mac_phase, issue_en, phase_end, out_free;
    logic               row_ok, col_ok, rd_row_ok, rd_col_ok;
    logic [IDX_W-1:0]   kk, km1;

    logic [NN_W-1:0]    a_addr, p_addr, q_addr, ap_addr;
    logic [IDX_W-1:0]   x_addr;
    logic [MN_W-1:0]    c_addr, pct_addr, gain_addr, cp_addr;
    logic [MM_W-1:0]    r_addr, inv_addr;
    logic [M_W-1:0]     ni_addr;
    logic signed [31:0] a_rd, x_rd, p_rd, c_rd, q_rd, r_rd, ap_rd;
    logic signed [31:0] pct_rd, inv_rd, gain_rd, ni_rd, cp_rd;
    logic signed [31:0] rd_data;
    logic [5:0]         rd_index;

    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != PH_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign issue_en  = mac_phase && !issue_done_reg;
    assign phase_end = issue_done_reg && !iss_reg.valid && !mac_busy;

    assign row_ok    = int'(cmd.row_index) < N;
    assign col_ok    = int'(cmd.col_index) < N;
    assign rd_row_ok = int'(rd_row_reg) < N;
    assign rd_col_ok = int'(rd_col_reg) < N;

    assign a_rd    = trans_reg[a_addr];
    assign x_rd    = est_reg[x_addr];
    assign p_rd    = cov_reg[p_addr];
    assign c_rd    = meas_reg[c_addr];
    assign q_rd    = pnoise_reg[q_addr];
    assign r_rd    = mnoise_reg[r_addr];
    assign ap_rd   = ap_reg[ap_addr];
    assign pct_rd  = pct_reg[pct_addr];
    assign inv_rd  = inv_reg[inv_addr];
    assign gain_rd = gain_reg[gain_addr];
    assign ni_rd   = ni_reg[ni_addr];
    assign cp_rd   = cp_reg[cp_addr];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PH_IDLE:
            begin
                if (cmd_acc && cmd.command == CMD_STEP)
                    state_next = PH_PRED_X;
                else if (cmd_acc && cmd.command == CMD_READ)
                    state_next = PH_READ;
            end
            PH_PRED_X: if (phase_end) state_next = PH_AP;
            PH_AP:     if (phase_end) state_next = PH_APAT;
            PH_APAT:   if (phase_end) state_next = PH_PCT;
            PH_PCT:    if (phase_end) state_next = PH_S;
            PH_S:      if (phase_end) state_next = PH_DET;
            PH_DET:
            begin
                if (phase_end)
                    state_next = (det_reg == '0) ? PH_EMIT : PH_DIV;
            end
            PH_DIV:
            begin
                if (div_done && inv_cnt_reg == MM_W'(M * M - 1))
                    state_next = PH_GAIN;
            end
            PH_GAIN:   if (phase_end) state_next = PH_INNOV;
            PH_INNOV:  if (phase_end) state_next = PH_XCORR;
            PH_XCORR:  if (phase_end) state_next = PH_CP;
            PH_CP:     if (phase_end) state_next = PH_PUPD;
            PH_PUPD:   if (phase_end) state_next = PH_EMIT;
            PH_EMIT:
            begin
                if (out_free && i_reg == IDX_W'(N - 1))
                    state_next = PH_IDLE;
            end
            PH_READ:   if (out_free) state_next = PH_IDLE;
            default:   state_next = PH_IDLE;
        endcase
    end

    // loop limits and store addresses
    always_comb
    begin
        mac_phase = 1'b0;
        i_lim     = '0;
        j_lim     = '0;
        k_lim     = '0;
        a_addr    = '0;
        x_addr    = '0;
        p_addr    = '0;
        c_addr    = '0;
        q_addr    = '0;
        r_addr    = '0;
        ap_addr   = '0;
        pct_addr  = '0;
        inv_addr  = '0;
        gain_addr = '0;
        ni_addr   = '0;
        cp_addr   = '0;
        kk        = k_reg[IDX_W-1:0];
        km1       = IDX_W'(k_reg - K_W'(1));
        unique case (state_reg)
            PH_PRED_X:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(N);
                a_addr    = NN_W'(fidx(i_reg, km1, N));
                x_addr    = (k_reg == '0) ? '0 : km1;
            end
            PH_AP:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                j_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(N - 1);
                a_addr    = NN_W'(fidx(i_reg, kk, N));
                p_addr    = NN_W'(fidx(kk, j_reg, N));
            end
            PH_APAT:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                j_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(N - 1);
                ap_addr   = NN_W'(fidx(i_reg, kk, N));
                a_addr    = NN_W'(fidx(j_reg, kk, N));
                q_addr    = NN_W'(fidx(i_reg, j_reg, N));
            end
            PH_PCT:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                j_lim     = IDX_W'(M - 1);
                k_lim     = K_W'(N - 1);
                p_addr    = NN_W'(fidx(i_reg, kk, N));
                c_addr    = MN_W'(fidx(j_reg, kk, N));
            end
            PH_S:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(M - 1);
                j_lim     = IDX_W'(M - 1);
                k_lim     = K_W'(N - 1);
                c_addr    = MN_W'(fidx(i_reg, kk, N));
                pct_addr  = MN_W'(fidx(kk, j_reg, M));
                r_addr    = MM_W'(fidx(i_reg, j_reg, M));
            end
            PH_DET:
            begin
                mac_phase = 1'b1;
                k_lim     = K_W'(1);
            end
            PH_GAIN:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                j_lim     = IDX_W'(M - 1);
                k_lim     = K_W'(M - 1);
                pct_addr  = MN_W'(fidx(i_reg, kk, M));
                inv_addr  = MM_W'(fidx(kk, j_reg, M));
            end
            PH_INNOV:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(M - 1);
                k_lim     = K_W'(N - 1);
                c_addr    = MN_W'(fidx(i_reg, kk, N));
                x_addr    = kk;
            end
            PH_XCORR:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(M - 1);
                gain_addr = MN_W'(fidx(i_reg, kk, M));
                ni_addr   = kk[M_W-1:0];
                x_addr    = i_reg;
            end
            PH_CP:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(M - 1);
                j_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(N - 1);
                c_addr    = MN_W'(fidx(i_reg, kk, N));
                p_addr    = NN_W'(fidx(kk, j_reg, N));
            end
            PH_PUPD:
            begin
                mac_phase = 1'b1;
                i_lim     = IDX_W'(N - 1);
                j_lim     = IDX_W'(N - 1);
                k_lim     = K_W'(M - 1);
                gain_addr = MN_W'(fidx(i_reg, kk, M));
                cp_addr   = MN_W'(fidx(kk, j_reg, N));
                p_addr    = NN_W'(fidx(i_reg, j_reg, N));
            end
            PH_EMIT:
            begin
                x_addr = i_reg;
            end
            PH_READ:
            begin
                x_addr = rd_row_reg[IDX_W-1:0];
                p_addr = NN_W'(fidx(rd_row_reg, rd_col_reg, N));
            end
            default:
            begin
                mac_phase = 1'b0;
            end
        endcase
    end

    // operand selection
    always_comb
    begin
        opa      = '0;
        opb      = '0;
        init_val = '0;
        sub      = 1'b0;
        dest     = '0;
        case (state_reg)
            PH_PRED_X:
            begin
                opa  = (k_reg == '0) ? inp_reg[i_reg] : a_rd;
                opb  = (k_reg == '0) ? u_reg : x_rd;
                dest = NN_W'(i_reg);
            end
            PH_AP:
            begin
                opa  = a_rd;
                opb  = p_rd;
                dest = NN_W'(fidx(i_reg, j_reg, N));
            end
            PH_APAT:
            begin
                opa      = ap_rd;
                opb      = a_rd;
                init_val = q_rd;
                dest     = NN_W'(fidx(i_reg, j_reg, N));
            end
            PH_PCT:
            begin
                opa  = p_rd;
                opb  = c_rd;
                dest = NN_W'(fidx(i_reg, j_reg, M));
            end
            PH_S:
            begin
                opa      = c_rd;
                opb      = pct_rd;
                init_val = r_rd;
                dest     = NN_W'(fidx(i_reg, j_reg, M));
            end
            PH_DET:
            begin
                opa = (k_reg == '0) ? s_reg[0] : s_reg[1];
                opb = (k_reg == '0) ? s_reg[3] : s_reg[2];
                sub = (k_reg != '0);
            end
            PH_GAIN:
            begin
                opa  = pct_rd;
                opb  = inv_rd;
                dest = NN_W'(fidx(i_reg, j_reg, M));
            end
            PH_INNOV:
            begin
                opa      = c_rd;
                opb      = x_rd;
                init_val = y_reg[i_reg[M_W-1:0]];
                sub      = 1'b1;
                dest     = NN_W'(i_reg);
            end
            PH_XCORR:
            begin
                opa      = gain_rd;
                opb      = ni_rd;
                init_val = x_rd;
                dest     = NN_W'(i_reg);
            end
            PH_CP:
            begin
                opa  = c_rd;
                opb  = p_rd;
                dest = NN_W'(fidx(i_reg, j_reg, N));
            end
            PH_PUPD:
            begin
                opa      = gain_rd;
                opb      = cp_rd;
                init_val = p_rd;
                sub      = 1'b1;
                dest     = NN_W'(fidx(i_reg, j_reg, N));
            end
            default:
            begin
                opa = '0;
            end
        endcase
        iss_next.valid = issue_en;
        iss_next.first = (k_reg == '0);
        iss_next.last  = (k_reg == k_lim);
        iss_next.sub   = sub;
        iss_next.tag   = state_reg;
        iss_next.addr  = dest;
        iss_next.init  = init_val;
    end

    // divider operands
    always_comb
    begin
        case (inv_cnt_reg)
            2'd0:    div_sx = QW'(s_reg[3]);
            2'd1:    div_sx = -QW'(s_reg[1]);
            2'd2:    div_sx = -QW'(s_reg[2]);
            default: div_sx = QW'(s_reg[0]);
        endcase
        div_sh    = div_sx <<< FRAC_W;
        div_num   = div_sh;
        div_start = (state_reg == PH_DIV) && !div_run_reg;
    end

    // read data
    always_comb
    begin
        rd_data  = '0;
        rd_index = 6'(fidx(rd_row_reg, rd_col_reg, N));
        if (rd_sel_reg == SEL_COV)
        begin
            if (rd_row_ok && rd_col_ok)
                rd_data = p_rd;
        end
        else
        begin
            rd_index = 6'(rd_row_reg);
            if (rd_sel_reg == SEL_EST && rd_row_ok)
                rd_data = x_rd;
        end
    end

    kfis_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (iss_reg),
        .opa  (opa_reg),
        .opb  (opb_reg),
        .wb   (wb),
        .busy (mac_busy)
    );

    kfis_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (det_reg),
        .done (div_done),
        .quo  (div_quo)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= PH_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            inv_cnt_reg    <= '0;
            issue_done_reg <= 1'b0;
            div_run_reg    <= 1'b0;
            smz_reg        <= 1'b0;
            sing_reg       <= 1'b0;
            iss_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
            if (cfg_write)
                smz_reg <= cfg_data;
            if (cmd_acc && cmd.command == CMD_STEP)
                sing_reg <= 1'b0;
            else if (state_reg == PH_DET && state_next == PH_EMIT)
                sing_reg <= 1'b1;

            if (state_reg != state_next)
            begin
                i_reg          <= '0;
                j_reg          <= '0;
                k_reg          <= '0;
                inv_cnt_reg    <= '0;
                issue_done_reg <= 1'b0;
                div_run_reg    <= 1'b0;
            end
            else if (issue_en)
            begin
                if (k_reg == k_lim)
                begin
                    k_reg <= '0;
                    if (j_reg == j_lim)
                    begin
                        j_reg <= '0;
                        if (i_reg == i_lim)
                            issue_done_reg <= 1'b1;
                        else
                            i_reg <= i_reg + IDX_W'(1);
                    end
                    else
                        j_reg <= j_reg + IDX_W'(1);
                end
                else
                    k_reg <= k_reg + K_W'(1);
            end
            else if (state_reg == PH_DIV)
            begin
                if (div_start)
                    div_run_reg <= 1'b1;
                else if (div_done)
                begin
                    div_run_reg <= 1'b0;
                    inv_cnt_reg <= inv_cnt_reg + MM_W'(1);
                end
            end
            else if (state_reg == PH_EMIT && out_free)
                i_reg <= i_reg + IDX_W'(1);

            if ((state_reg == PH_EMIT || state_reg == PH_READ) && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // estimate and covariance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < N; r++)
                est_reg[r] <= '0;
            for (int e = 0; e < N * N; e++)
                cov_reg[e] <= (e % (N + 1) == 0) ? INIT_VARIANCE : '0;
        end
        else
        begin
            if (cmd_acc && cmd.command == CMD_INIT)
            begin
                for (int r = 0; r < N; r++)
                    est_reg[r] <= '0;
                for (int e = 0; e < N * N; e++)
                    cov_reg[e] <= (e % (N + 1) == 0) ? INIT_VARIANCE : '0;
            end
            else if (cmd_acc && cmd.command == CMD_WRITE_GUESS)
            begin
                if (cmd.matrix_sel == SEL_EST && row_ok)
                    est_reg[cmd.row_index[IDX_W-1:0]] <= cmd.value;
                else if (cmd.matrix_sel == SEL_COV && row_ok && col_ok)
                    cov_reg[NN_W'(fidx(cmd.row_index, cmd.col_index, N))] <= cmd.value;
            end
            if (state_reg == PH_PRED_X && state_next == PH_AP)
            begin
                for (int r = 0; r < N; r++)
                    est_reg[r] <= tv_reg[r];
            end
            if (wb.valid && wb.tag == PH_XCORR)
                est_reg[wb.addr[IDX_W-1:0]] <= sat32(wb.acc);
            if (wb.valid && (wb.tag == PH_APAT || wb.tag == PH_PUPD))
                cov_reg[wb.addr] <= sat32(wb.acc);
        end
    end

    // model store, captured operands, scratch
    always_ff @(posedge clk)
    begin
        opa_reg <= opa;
        opb_reg <= opb;
        if (cmd_acc)
        begin
            u_reg      <= cmd.control_input;
            y_reg[0]   <= cmd.meas_first;
            y_reg[1]   <= smz_reg ? '0 : cmd.meas_second;
            rd_sel_reg <= cmd.matrix_sel;
            rd_row_reg <= cmd.row_index;
            rd_col_reg <= cmd.col_index;
        end
        if (cmd_acc && cmd.command == CMD_WRITE_MODEL)
        begin
            if (cmd.matrix_sel == SEL_A && row_ok && col_ok)
                trans_reg[NN_W'(fidx(cmd.row_index, cmd.col_index, N))] <= cmd.value;
            else if (cmd.matrix_sel == SEL_B && row_ok)
                inp_reg[cmd.row_index[IDX_W-1:0]] <= cmd.value;
            else if (cmd.matrix_sel == SEL_C && int'(cmd.row_index) < M && col_ok)
                meas_reg[MN_W'(fidx(cmd.row_index, cmd.col_index, N))] <= cmd.value;
            else if (cmd.matrix_sel == SEL_Q && row_ok && col_ok)
                pnoise_reg[NN_W'(fidx(cmd.row_index, cmd.col_index, N))] <= cmd.value;
            else if (cmd.matrix_sel == SEL_R && int'(cmd.row_index) < M
                     && int'(cmd.col_index) < M)
                mnoise_reg[MM_W'(fidx(cmd.row_index, cmd.col_index, M))] <= cmd.value;
        end
        if (wb.valid)
        begin
            case (wb.tag)
                PH_PRED_X: tv_reg[wb.addr[IDX_W-1:0]]  <= sat32(wb.acc);
                PH_AP:     ap_reg[wb.addr]             <= sat32(wb.acc);
                PH_PCT:    pct_reg[wb.addr[MN_W-1:0]]  <= sat32(wb.acc);
                PH_S:      s_reg[wb.addr[MM_W-1:0]]    <= sat32(wb.acc);
                PH_DET:    det_reg                     <= wb.acc[QW-1:0];
                PH_GAIN:   gain_reg[wb.addr[MN_W-1:0]] <= sat32(wb.acc);
                PH_INNOV:  ni_reg[wb.addr[M_W-1:0]]    <= sat32(wb.acc);
                PH_CP:     cp_reg[wb.addr[MN_W-1:0]]   <= sat32(wb.acc);
                default:   ;
            endcase
        end
        if (div_done)
            inv_reg[inv_cnt_reg] <= div_quo;
        if (state_reg == PH_EMIT && out_free)
        begin
            res_reg.kind          <= KIND_EST;
            res_reg.element_index <= 6'(i_reg);
            res_reg.data          <= x_rd;
            res_reg.singular      <= sing_reg;
            res_reg.last          <= (i_reg == IDX_W'(N - 1));
        end
        else if (state_reg == PH_READ && out_free)
        begin
            res_reg.kind          <= KIND_READ;
            res_reg.element_index <= rd_index;
            res_reg.data          <= rd_data;
            res_reg.singular      <= 1'b0;
            res_reg.last          <= 1'b1;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/kfis_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfis_mac
// Shared multiply, round and accumulate unit: one product per cycle, two stages.
// ----------------------------------------------------------------------------
module kfis_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kfis_pkg::mac_req_t       req,
    input  logic signed [31:0]       opa,
    input  logic signed [31:0]       opb,
    output kfis_pkg::mac_wb_t        wb,
    output logic                     busy
);
    import kfis_pkg::*;

    mac_req_t                 req1_reg;
    mac_wb_t                  wb_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_next;

    assign rnd      = (prod_reg + ROUND_HALF) >>> FRAC_W;
    assign base     = req1_reg.first ? ACC_W'(req1_reg.init) : acc_reg;
    assign acc_next = req1_reg.sub ? (base - rnd) : (base + rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req1_reg <= '0;
            wb_reg   <= '0;
        end
        else
        begin
            req1_reg     <= req;
            wb_reg.valid <= req1_reg.valid && req1_reg.last;
            wb_reg.tag   <= req1_reg.tag;
            wb_reg.addr  <= req1_reg.addr;
            wb_reg.acc   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(opa) * ACC_W'(opb);
        if (req1_reg.valid)
            acc_reg <= acc_next;
    end

    assign wb   = wb_reg;
    assign busy = req1_reg.valid || wb_reg.valid;

endmodule

// ----- rtl/kfis_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfis_div
// Signed restoring divider, one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
module kfis_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [kfis_pkg::QW-1:0] num,
    input  logic signed [kfis_pkg::QW-1:0] den,
    output logic                          done,
    output logic signed [31:0]            quo
);
    import kfis_pkg::*;

    logic              run_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              neg_reg;
    logic [MAG_W:0]    rem_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  dmag_reg;
    logic [QW-1:0]     nabs;
    logic [QW-1:0]     dabs;
    logic [MAG_W:0]    rem_sh;
    logic              ge;
    logic signed [QW-1:0] qs;

    assign nabs   = num[QW-1] ? QW'(-num) : QW'(num);
    assign dabs   = den[QW-1] ? QW'(-den) : QW'(den);
    assign rem_sh = {rem_reg[MAG_W-1:0], quo_reg[MAG_W-1]};
    assign ge     = rem_sh >= {1'b0, dmag_reg};
    assign qs     = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(MAG_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num[QW-1] ^ den[QW-1];
            rem_reg  <= '0;
            quo_reg  <= nabs[MAG_W-1:0];
            dmag_reg <= dabs[MAG_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sat32(ACC_W'(qs));

endmodule

// ----- bench/kfis_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfis_checker
// Watches the command and result channels of the Kalman filter step core,
// keeps its own copy of model, estimate and covariance, predicts every
// result item in Q16.16 and compares the items field by field in order.
// ----------------------------------------------------------------------------
module kfis_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  kfis_pkg::cmd_t    cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  kfis_pkg::res_t    res,
    input  logic              cfg_write,
    input  logic              cfg_data,
    output int                errors,
    output int                pending,
    output int                steps_seen,
    output int                singular_seen
);
    import kfis_pkg::*;

    localparam int N = STATE_DIM;
    localparam int M = MEAS_DIM;
    localparam int FIFO_DEPTH = 64;

    logic signed [31:0] a_m [N*N];
    logic signed [31:0] b_v [N];
    logic signed [31:0] c_m [M*N];
    logic signed [31:0] q_m [N*N];
    logic signed [31:0] r_m [M*M];
    logic signed [31:0] x_v [N];
    logic signed [31:0] p_m [N*N];
    logic signed [31:0] g_m [N*M];
    logic               y2_zero;

    res_t want_fifo [FIFO_DEPTH];
    int   put_count;
    int   take_count;

    function automatic logic signed [63:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        logic signed [63:0] t;
        t = 64'(a) * 64'(b) + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic want_put(input res_t r);
        if (put_count - take_count >= FIFO_DEPTH)
            report("expected item overflow", 64'(put_count - take_count), 64'(FIFO_DEPTH));
        else
        begin
            want_fifo[put_count % FIFO_DEPTH] = r;
            put_count++;
        end
    endtask

    task automatic reset_estimate();
        for (int i = 0; i < N*N; i++)
            p_m[i] = (i % (N + 1) == 0) ? INIT_VARIANCE : 32'sd0;
        for (int i = 0; i < N; i++)
            x_v[i] = 0;
    endtask

    task automatic filter_step(input logic signed [31:0] u, input logic signed [31:0] y0,
                               input logic signed [31:0] y1, output logic sing);
        logic signed [31:0] ap [N*N];
        logic signed [31:0] pct [N*M];
        logic signed [31:0] cp [M*N];
        logic signed [31:0] s [M*M];
        logic signed [31:0] inv [M*M];
        logic signed [31:0] ni [M];
        logic signed [31:0] y [M];
        logic signed [31:0] xp [N];
        logic signed [63:0] acc;
        logic signed [63:0] det;
        y[0] = y0;
        y[1] = y1;
        for (int i = 0; i < N; i++)
        begin
            acc = fx_mul(b_v[i], u);
            for (int k = 0; k < N; k++)
                acc += fx_mul(a_m[i*N+k], x_v[k]);
            xp[i] = clip32(acc);
        end
        x_v = xp;
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
            begin
                acc = 0;
                for (int k = 0; k < N; k++)
                    acc += fx_mul(a_m[i*N+k], p_m[k*N+j]);
                ap[i*N+j] = clip32(acc);
            end
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
            begin
                acc = 64'(q_m[i*N+j]);
                for (int k = 0; k < N; k++)
                    acc += fx_mul(ap[i*N+k], a_m[j*N+k]);
                p_m[i*N+j] = clip32(acc);
            end
        for (int i = 0; i < N; i++)
            for (int j = 0; j < M; j++)
            begin
                acc = 0;
                for (int k = 0; k < N; k++)
                    acc += fx_mul(p_m[i*N+k], c_m[j*N+k]);
                pct[i*M+j] = clip32(acc);
            end
        for (int j = 0; j < M; j++)
            for (int i = 0; i < M; i++)
            begin
                acc = 64'(r_m[j*M+i]);
                for (int k = 0; k < N; k++)
                    acc += fx_mul(c_m[j*N+k], pct[k*M+i]);
                s[j*M+i] = clip32(acc);
            end
        det = fx_mul(s[0], s[3]) - fx_mul(s[1], s[2]);
        sing = (det == 0);
        if (sing)
            return;
        inv[0] = clip32((64'(s[3]) * 64'sd65536) / det);
        inv[1] = clip32((-64'(s[1]) * 64'sd65536) / det);
        inv[2] = clip32((-64'(s[2]) * 64'sd65536) / det);
        inv[3] = clip32((64'(s[0]) * 64'sd65536) / det);
        for (int i = 0; i < N; i++)
            for (int j = 0; j < M; j++)
                g_m[i*M+j] = clip32(fx_mul(pct[i*M], inv[j]) + fx_mul(pct[i*M+1], inv[M+j]));
        for (int j = 0; j < M; j++)
        begin
            acc = 0;
            for (int k = 0; k < N; k++)
                acc += fx_mul(c_m[j*N+k], x_v[k]);
            ni[j] = clip32(64'(y[j]) - acc);
        end
        for (int i = 0; i < N; i++)
        begin
            acc = 64'(x_v[i]);
            for (int j = 0; j < M; j++)
                acc += fx_mul(g_m[i*M+j], ni[j]);
            x_v[i] = clip32(acc);
        end
        for (int j = 0; j < M; j++)
            for (int k = 0; k < N; k++)
            begin
                acc = 0;
                for (int i = 0; i < N; i++)
                    acc += fx_mul(c_m[j*N+i], p_m[i*N+k]);
                cp[j*N+k] = clip32(acc);
            end
        for (int i = 0; i < N; i++)
            for (int k = 0; k < N; k++)
            begin
                acc = 64'(p_m[i*N+k]);
                for (int j = 0; j < M; j++)
                    acc -= fx_mul(g_m[i*M+j], cp[j*N+k]);
                p_m[i*N+k] = clip32(acc);
            end
    endtask

    task automatic predict_item(input cmd_t c);
        logic rok;
        logic cok;
        int mi;
        logic sing;
        res_t r;
        rok = c.row_index < N;
        cok = c.col_index < N;
        mi = c.row_index * N + c.col_index;
        case (c.command)
            CMD_WRITE_MODEL:
            begin
                if (c.matrix_sel == SEL_A && rok && cok)
                    a_m[mi] = c.value;
                else if (c.matrix_sel == SEL_B && rok)
                    b_v[c.row_index[IDX_W-1:0]] = c.value;
                else if (c.matrix_sel == SEL_C && c.row_index < M && cok)
                    c_m[mi] = c.value;
                else if (c.matrix_sel == SEL_Q && rok && cok)
                    q_m[mi] = c.value;
                else if (c.matrix_sel == SEL_R && c.row_index < M && c.col_index < M)
                    r_m[c.row_index * M + c.col_index] = c.value;
            end
            CMD_INIT:
                reset_estimate();
            CMD_WRITE_GUESS:
            begin
                if (c.matrix_sel == SEL_EST && rok)
                    x_v[c.row_index[IDX_W-1:0]] = c.value;
                else if (c.matrix_sel == SEL_COV && rok && cok)
                    p_m[mi] = c.value;
            end
            CMD_STEP:
            begin
                filter_step(c.control_input, c.meas_first,
                            y2_zero ? 32'sd0 : c.meas_second, sing);
                steps_seen++;
                if (sing)
                    singular_seen++;
                for (int i = 0; i < N; i++)
                begin
                    r.kind = KIND_EST;
                    r.element_index = 6'(i);
                    r.data = x_v[i];
                    r.singular = sing;
                    r.last = (i == N - 1);
                    want_put(r);
                end
            end
            CMD_READ:
            begin
                r.kind = KIND_READ;
                r.singular = 1'b0;
                r.last = 1'b1;
                r.data = 0;
                if (c.matrix_sel == SEL_COV)
                begin
                    r.element_index = 6'(mi);
                    if (rok && cok)
                        r.data = p_m[mi];
                end
                else
                begin
                    r.element_index = 6'(c.row_index);
                    if (c.matrix_sel == SEL_EST && rok)
                        r.data = x_v[c.row_index[IDX_W-1:0]];
                end
                want_put(r);
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        errors = 0;
        steps_seen = 0;
        singular_seen = 0;
        put_count = 0;
        take_count = 0;
        y2_zero = 0;
        for (int i = 0; i < N*N; i++)
        begin
            a_m[i] = 0;
            q_m[i] = 0;
        end
        for (int i = 0; i < N; i++)
            b_v[i] = 0;
        for (int i = 0; i < M*N; i++)
        begin
            c_m[i] = 0;
            g_m[i] = 0;
        end
        for (int i = 0; i < M*M; i++)
            r_m[i] = 0;
        reset_estimate();
    end

    assign pending = put_count - take_count;

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cfg_write)
                y2_zero <= cfg_data;
            if (res_valid && !res_stall)
            begin
                if (put_count == take_count)
                    report("unexpected item", 64'(res), 64'd0);
                else
                begin
                    want = want_fifo[take_count % FIFO_DEPTH];
                    take_count++;
                    if (res.kind !== want.kind)
                        report("kind", 64'(res.kind), 64'(want.kind));
                    if (res.element_index !== want.element_index)
                        report("element_index", 64'(res.element_index),
                               64'(want.element_index));
                    if (res.data !== want.data)
                        report("data", 64'(res.data), 64'(want.data));
                    if (res.singular !== want.singular)
                        report("singular", 64'(res.singular), 64'(want.singular));
                    if (res.last !== want.last)
                        report("last", 64'(res.last), 64'(want.last));
                end
            end
            if (cmd_valid && !cmd_stall)
                predict_item(cmd);
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the Kalman filter step core: model loads, inits,
// guesses, steps and reads, directed then random, with random idle bursts on
// both channels, a long result hold-off and a drain pause; the checker
// compares every result item and reports each mismatch.
// ----------------------------------------------------------------------------
module testbench;
    import kfis_pkg::*;

    localparam int N = STATE_DIM;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic cfg_write;
    logic cfg_data;
    int errors;
    int pending;
    int steps_seen;
    int singular_seen;
    int sent;
    longint cycles;
    logic src_idle_on;
    logic sink_idle_on;
    logic hold_sink;

    kalman_filter_with_input_step_core uut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    kfis_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .errors(errors), .pending(pending),
        .steps_seen(steps_seen), .singular_seen(singular_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver stall: random bursts, or a long hold-off when asked
    initial
    begin
        int burst;
        res_stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                res_stall <= 1;
                for (int i = 0; i < 3000; i++)
                    @(posedge clk);
                res_stall <= 0;
                hold_sink = 0;
            end
            else if (sink_idle_on && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18);
                res_stall <= 1;
                repeat (burst) @(posedge clk);
                res_stall <= 0;
            end
        end
    end

    function automatic logic signed [31:0] rand_q(input int lim);
        logic signed [31:0] v;
        v = $signed($urandom_range(0, 2 * lim)) - lim;
        return v;
    endfunction

    function automatic logic signed [31:0] rand_wide();
        case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send(input cmd_t c);
        int burst;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 18);
            cmd_valid <= 0;
            repeat (burst) @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1;
        do
            @(posedge clk);
        while (cmd_stall);
        sent++;
    endtask

    task automatic drain();
        cmd_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic cmd_t mk(input logic [2:0] op, input logic [2:0] sel,
                                input logic [2:0] r, input logic [2:0] c,
                                input logic signed [31:0] v);
        cmd_t t;
        t.command = op;
        t.matrix_sel = sel;
        t.row_index = r;
        t.col_index = c;
        t.value = v;
        t.control_input = rand_wide();
        t.meas_first = rand_wide();
        t.meas_second = rand_wide();
        return t;
    endfunction

    function automatic cmd_t mk_step(input int lim);
        cmd_t t;
        t = mk(CMD_STEP, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               3'($urandom_range(0, 7)), $signed($urandom()));
        t.control_input = rand_q(lim);
        t.meas_first = rand_q(lim);
        t.meas_second = rand_q(lim);
        return t;
    endfunction

    // full model load: A near identity, small B, C, Q, R
    task automatic load_model(input int spread);
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                send(mk(CMD_WRITE_MODEL, SEL_A, 3'(i), 3'(j),
                        (i == j ? 32'sd65536 : 32'sd0) + rand_q(spread)));
        for (int i = 0; i < N; i++)
            send(mk(CMD_WRITE_MODEL, SEL_B, 3'(i), 3'($urandom_range(0, 7)),
                    rand_q(40000)));
        for (int i = 0; i < MEAS_DIM; i++)
            for (int j = 0; j < N; j++)
                send(mk(CMD_WRITE_MODEL, SEL_C, 3'(i), 3'(j), rand_q(70000)));
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                send(mk(CMD_WRITE_MODEL, SEL_Q, 3'(i), 3'(j),
                        i == j ? rand_q(3000) + 32'sd3000 : rand_q(300)));
        for (int i = 0; i < MEAS_DIM; i++)
            for (int j = 0; j < MEAS_DIM; j++)
                send(mk(CMD_WRITE_MODEL, SEL_R, 3'(i), 3'(j),
                        i == j ? rand_q(30000) + 32'sd40000 : rand_q(2000)));
    endtask

    task automatic set_flag(input logic v);
        cfg_write <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    function automatic cmd_t rand_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return mk_step(400000);
        if (pick < 60)
            return mk(CMD_READ, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), $signed($urandom()));
        if (pick < 72)
            return mk(CMD_WRITE_GUESS, 3'($urandom_range(0, 2)),
                      3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
                      rand_q(300000));
        if (pick < 80)
            return mk(CMD_INIT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), $signed($urandom()));
        if (pick < 92)
            return mk(CMD_WRITE_MODEL, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      $urandom_range(0, 1) ? rand_q(8000) : rand_wide());
        return mk(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $signed($urandom()));
    endfunction

    initial
    begin
        cmd_t t;
        rst_n = 0;
        cmd_valid = 0;
        cmd = '0;
        cfg_write = 0;
        cfg_data = 0;
        sent = 0;
        src_idle_on = 1;
        sink_idle_on = 1;
        hold_sink = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset values, out-of-range reads, writes, singular step, extreme-input step
        send(mk(CMD_READ, SEL_COV, 3'd0, 3'd0, 0));
        send(mk(CMD_READ, SEL_EST, 3'd3, 3'd7, 0));
        send(mk(CMD_READ, SEL_COV, 3'd7, 3'd7, 0));
        send(mk(CMD_READ, 3'd5, 3'd6, 3'd1, 0));
        send(mk(CMD_WRITE_GUESS, SEL_COV, 3'd1, 3'd2, 32'sh7fffffff));
        send(mk(CMD_WRITE_GUESS, SEL_EST, 3'd7, 3'd0, 32'sh80000000));
        send(mk(CMD_WRITE_GUESS, 3'd6, 3'd0, 3'd0, 32'sd1));
        send(mk(CMD_READ, SEL_COV, 3'd1, 3'd2, 0));
        send(mk(CMD_WRITE_MODEL, SEL_R, 3'd2, 3'd0, 32'sd5));
        send(mk(CMD_WRITE_MODEL, 3'd7, 3'd0, 3'd0, 32'sd5));
        send(mk(3'd7, 3'd0, 3'd0, 3'd0, 32'sd5));
        send(mk(CMD_INIT, 3'd0, 3'd0, 3'd0, 0));
        // all-zero model gives a zero determinant
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
            begin
                send(mk(CMD_WRITE_MODEL, SEL_A, 3'(i), 3'(j), 0));
                send(mk(CMD_WRITE_MODEL, SEL_Q, 3'(i), 3'(j), 0));
            end
        for (int i = 0; i < N; i++)
        begin
            send(mk(CMD_WRITE_MODEL, SEL_B, 3'(i), 3'd0, 0));
            send(mk(CMD_WRITE_MODEL, SEL_C, 3'd0, 3'(i), 0));
            send(mk(CMD_WRITE_MODEL, SEL_C, 3'd1, 3'(i), 0));
        end
        for (int i = 0; i < 4; i++)
            send(mk(CMD_WRITE_MODEL, SEL_R, 3'(i / 2), 3'(i % 2), 0));
        send(mk_step(65536));
        load_model(4000);
        t = mk_step(0);
        t.control_input = 32'sh7fffffff;
        t.meas_first = 32'sh80000000;
        t.meas_second = 32'sh7fffffff;
        send(t);
        send(mk(CMD_READ, SEL_COV, 3'd3, 3'd3, 0));
        drain();
        set_flag(1);

        // random phases with changing flag and models
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
            begin
                src_idle_on = 0;
                sink_idle_on = 0;
            end
            for (int i = 0; i < 12; i++)
            begin
                if (ph == 2 && i == 5)
                begin
                    hold_sink = 1;
                    send(mk_step(400000));
                end
                else
                    send(rand_item());
            end
            if (ph == 3)
                load_model(20000);
            drain();
            set_flag(ph % 2);
        end

        while (hold_sink)
            @(posedge clk);
        drain();
        $display("sent %0d command items, %0d steps (%0d singular)",
                 sent, steps_seen, singular_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- kalman_filter_with_input_step_core.f -----
rtl/kfis_pkg.sv
rtl/kfis_mac.sv
rtl/kfis_div.sv
rtl/kalman_filter_with_input_step_core.sv
bench/kfis_checker.sv
bench/testbench.sv
